FILE: rtl/assert_macros.svh
// Assertion helpers, clocked on clk_i and held off while rst_ni is low
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every rising edge of clk_i
`define GSC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Property that must hold whenever the guard is high
`define GSC_ASSERT_WHEN(lbl, guard, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (guard) |-> (prop)) \
    else $error(msg);

`endif

FILE: rtl/gsc_pkg.sv
package gsc_pkg;

  localparam int LumaTableDepth = 256;
  localparam int LumaIdxW       = $clog2(LumaTableDepth);

  localparam int ModeW = 2;

  localparam logic [ModeW-1:0] FmtPalette = 2'd0;
  localparam logic [ModeW-1:0] FmtRgb16   = 2'd1;
  localparam logic [ModeW-1:0] FmtRgb24   = 2'd2;
  localparam logic [ModeW-1:0] FmtRgb32   = 2'd3;

  localparam int PixelW = 32;
  localparam int PalW   = 10;

  // weights in thousandths
  localparam int WeightRed   = 302;
  localparam int WeightGreen = 589;
  localparam int WeightBlue  = 114;
  localparam int LumaDiv     = 1000;

  // x / 3 == (x * 2731) >> 13 for x < 8192
  localparam int DivThreeMul   = 2731;
  localparam int DivThreeShift = 13;

  typedef logic [LumaTableDepth-1:0][7:0] luma_table_t;

  // entry i of a luma ROM: floor(i * weight / 1000)
  function automatic luma_table_t luma_table(input int weight);
    luma_table_t t;
    for (int i = 0; i < LumaTableDepth; i++) begin
      t[i] = 8'((i * weight) / LumaDiv);
    end
    return t;
  endfunction

  localparam luma_table_t LumaRomRed   = luma_table(WeightRed);
  localparam luma_table_t LumaRomGreen = luma_table(WeightGreen);
  localparam luma_table_t LumaRomBlue  = luma_table(WeightBlue);

endpackage

FILE: rtl/gsc_luma.sv
module gsc_luma import gsc_pkg::*; (
  input  logic [ModeW-1:0]  mode_i,
  input  logic [PixelW-1:0] pixel_word_i,
  output logic [PixelW-1:0] pixel_out_o
);

  logic [LumaIdxW-1:0] red, green, blue;
  logic [8:0]          sum;
  logic [7:0]          gray;
  logic [7:0]          half;
  logic [15:0]         pack16;

  always_comb begin
    case (mode_i)
      FmtRgb16: begin
        red   = {2'b00, pixel_word_i[4:0], 1'b0};
        green = {3'b000, pixel_word_i[10:6]};
        blue  = {2'b00, pixel_word_i[15:11], 1'b0};
      end
      FmtRgb24: begin
        red   = pixel_word_i[23:16];
        green = pixel_word_i[15:8];
        blue  = pixel_word_i[7:0];
      end
      FmtRgb32: begin
        red   = pixel_word_i[31:24];
        green = pixel_word_i[23:16];
        blue  = pixel_word_i[15:8];
      end
      default: begin
        red   = '0;
        green = '0;
        blue  = '0;
      end
    endcase
  end

  assign sum  = 9'(LumaRomRed[red]) + 9'(LumaRomGreen[green]) + 9'(LumaRomBlue[blue]);
  assign gray = sum[8] ? 8'hFF : sum[7:0];
  assign half = {1'b0, gray[7:1]};

  // fields overlap in 565 packing, so add rather than OR
  assign pack16 = 16'((19'(half) << 11) + (19'(gray) << 5) + 19'(half));

  always_comb begin
    case (mode_i)
      FmtRgb16: pixel_out_o = {16'h0000, pack16};
      FmtRgb24: pixel_out_o = {8'h00, gray, gray, gray};
      FmtRgb32: pixel_out_o = {gray, gray, gray, 8'h00};
      default:  pixel_out_o = '0;
    endcase
  end

endmodule

FILE: rtl/gsc_pal_avg.sv
module gsc_pal_avg import gsc_pkg::*; (
  input  logic [PalW-1:0] pal_red_i,
  input  logic [PalW-1:0] pal_green_i,
  input  logic [PalW-1:0] pal_blue_i,
  output logic [PalW-1:0] pal_gray_o
);

  localparam int SumW  = PalW + 2;
  localparam int ProdW = SumW + 12;

  logic [SumW-1:0]  sum;
  logic [ProdW-1:0] prod;

  assign sum  = SumW'(pal_red_i) + SumW'(pal_green_i) + SumW'(pal_blue_i);
  assign prod = ProdW'(sum) * ProdW'(DivThreeMul);
  assign pal_gray_o = prod[DivThreeShift +: PalW];

endmodule

FILE: rtl/pixel_grayscale_converter.sv
// Gray conversion of one pixel or palette entry per word. Throughput is one word per
// clock while the output is not stalled. An input register is followed by a result
// register, with the luma ROM lookups, the saturating sum and the repacking (or the
// divide by three of the palette average) between them. in_ready_o follows out_ready_i
// combinationally, so a stalled output holds back the input only once both registers
// are full. format_mode_i selects palette, 16-, 24- or 32-bit pixels and resets to palette;
// the user must write it through the cfg port while no word is in flight; the block does not enforce it.
`include "assert_macros.svh"

module pixel_grayscale_converter import gsc_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,

  input  logic              cfg_valid_i,
  output logic              cfg_ready_o,
  input  logic [ModeW-1:0]  format_mode_i,

  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [PixelW-1:0] pixel_word_i,
  input  logic [PalW-1:0]   pal_red_i,
  input  logic [PalW-1:0]   pal_green_i,
  input  logic [PalW-1:0]   pal_blue_i,

  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [PixelW-1:0] pixel_out_o,
  output logic [PalW-1:0]   pal_gray_o
);

  logic [ModeW-1:0]  mode_q;

  logic              s1_valid_q, s1_valid_d;
  logic [PixelW-1:0] pixel_word_q;
  logic [PalW-1:0]   pal_red_q, pal_green_q, pal_blue_q;

  logic              out_valid_q, out_valid_d;
  logic [PixelW-1:0] pixel_out_q;
  logic [PalW-1:0]   pal_gray_q;

  logic              s1_ready, s2_ready;
  logic [PixelW-1:0] luma_pixel;
  logic [PalW-1:0]   avg_gray;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= FmtPalette;
    end else if (cfg_valid_i) begin
      mode_q <= format_mode_i;
    end
  end

  assign s2_ready   = !out_valid_q || out_ready_i;
  assign s1_ready   = !s1_valid_q || s2_ready;
  assign in_ready_o = s1_ready;

  assign s1_valid_d  = s1_ready ? in_valid_i : s1_valid_q;
  assign out_valid_d = s2_ready ? s1_valid_q : out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && s1_ready) begin
      pixel_word_q <= pixel_word_i;
      pal_red_q    <= pal_red_i;
      pal_green_q  <= pal_green_i;
      pal_blue_q   <= pal_blue_i;
    end
  end

  gsc_luma u_luma (
    .mode_i       (mode_q),
    .pixel_word_i (pixel_word_q),
    .pixel_out_o  (luma_pixel)
  );

  gsc_pal_avg u_pal_avg (
    .pal_red_i   (pal_red_q),
    .pal_green_i (pal_green_q),
    .pal_blue_i  (pal_blue_q),
    .pal_gray_o  (avg_gray)
  );

  always_ff @(posedge clk_i) begin
    if (s1_valid_q && s2_ready) begin
      pixel_out_q <= luma_pixel;
      pal_gray_q  <= (mode_q == FmtPalette) ? avg_gray : '0;
    end
  end

  assign out_valid_o = out_valid_q;
  assign pixel_out_o = pixel_out_q;
  assign pal_gray_o  = pal_gray_q;

  `GSC_ASSERT_WHEN(a_stall_keeps_word, s1_valid_q && out_valid_q && !out_ready_i,
    ##1 s1_valid_q, "input register dropped a word during output stall")
  `GSC_ASSERT_WHEN(a_ready_only_when_full, !in_ready_o, s1_valid_q && out_valid_q,
    "input held off with a free register")
  `GSC_ASSERT_WHEN(a_palette_pixel_zero, out_valid_o && mode_q == FmtPalette,
    pixel_out_o == '0, "pixel word not zero in palette mode")
  `GSC_ASSERT_WHEN(a_pixel_pal_zero, out_valid_o && mode_q != FmtPalette,
    pal_gray_o == '0, "palette gray not zero in pixel mode")

endmodule
